/* rtl/pixel_front_to_back_composite_core_macros.svh */
// Assertion macros for the splat compositing core.
// Included by the top level only; no other dependencies.
`ifndef PIXEL_FRONT_TO_BACK_COMPOSITE_CORE_MACROS_SVH
`define PIXEL_FRONT_TO_BACK_COMPOSITE_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PFB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define PFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/pfb_pkg.sv */
// Package of the splat compositing core: shared types and constants.
// Used by the front, queue and back modules and by the top level.
package pfb_pkg;

  localparam logic [16:0] Q16_ONE   = 17'd65536;
  localparam logic [15:0] ALPHA_CAP = 16'd64881;
  localparam logic [17:0] ACC_MAX   = 18'h3FFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [2:0] REG_BG_RED    = 3'd0;
  localparam logic [2:0] REG_BG_GREEN  = 3'd1;
  localparam logic [2:0] REG_BG_BLUE   = 3'd2;
  localparam logic [2:0] REG_MIN_ALPHA = 3'd3;
  localparam logic [2:0] REG_STOP_T    = 3'd4;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic        keep;
    logic [15:0] alpha;
    logic [16:0] red;
    logic [16:0] green;
    logic [16:0] blue;
    logic        last;
  } pfb_item_t;

  // Back part states.
  typedef enum logic [1:0] {
    ST_WT,
    ST_ACC,
    ST_BGT,
    ST_OUT
  } pfb_state_t;

  function automatic logic [16:0] cap16(input logic [16:0] v);
    return (v > Q16_ONE) ? Q16_ONE : v;
  endfunction

endpackage

/* rtl/pfb_front.sv */
// Front part: box test, quadratic form, exp table lookup and alpha.
// Depends on pfb_pkg. Four-stage pipeline with stall on downstream ready.
module pfb_front #(
  parameter int EXP_TABLE_ENTRIES = 256,
  parameter int MAX_RADIUS        = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [7:0]    offset_x,
  input  logic signed [7:0]    offset_y,
  input  logic [6:0]           box_radius,
  input  logic signed [23:0]   conic_a,
  input  logic signed [23:0]   conic_b,
  input  logic signed [23:0]   conic_c,
  input  logic [16:0]          opacity,
  input  logic [16:0]          red,
  input  logic [16:0]          green,
  input  logic [16:0]          blue,
  input  logic                 last,
  input  logic [15:0]          min_alpha,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pfb_pkg::pfb_item_t   out_item
);
  localparam int IDXW = $clog2(EXP_TABLE_ENTRIES);

  // Exp table built at elaboration from the fixed-point recurrence.
  function automatic logic [16:0] exp_entry(input int k);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    logic [127:0] p;
    x = 64'(64'd1 << 35) / 64'(EXP_TABLE_ENTRIES);
    term = 64'd1 << 32;
    sum = term;
    for (int i = 1; i <= 13; i++) begin
      p = 128'(term) * 128'(x);
      term = 64'(p >> 32) / 64'(i);
      if (i % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    v = 64'd1 << 32;
    for (int i = 0; i < k; i++) begin
      p = 128'(v) * 128'(sum) + (128'd1 << 31);
      v = 64'(p >> 32);
    end
    return 17'((v + 64'd32768) >> 16);
  endfunction

  logic [16:0] exp_rom [EXP_TABLE_ENTRIES];
  for (genvar g = 0; g < EXP_TABLE_ENTRIES; g++) begin : g_rom
    assign exp_rom[g] = exp_entry(g);
  end

  logic adv;
  logic v1, v2, v3, v4;
  assign adv = !v4 || out_ready;
  assign in_ready = adv;

  // Stage 1: box test and products of offsets.
  logic signed [7:0] rad;
  logic inside_box;
  always_comb begin
    rad = (box_radius == 7'd0) ? 8'sd1 :
          (box_radius > 7'(MAX_RADIUS)) ? 8'(MAX_RADIUS) : 8'(box_radius);
    inside_box = (offset_x >= -rad) && (offset_x <= rad) &&
                 (offset_y >= -rad) && (offset_y <= rad);
  end

  logic signed [15:0] s1_xx, s1_xy, s1_yy;
  logic signed [23:0] s1_a, s1_b, s1_c;
  logic s1_in, s1_last;
  logic [16:0] s1_op, s1_r, s1_g, s1_bl;
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_xx <= offset_x * offset_x;
      s1_xy <= offset_x * offset_y;
      s1_yy <= offset_y * offset_y;
      s1_a <= conic_a; s1_b <= conic_b; s1_c <= conic_c;
      s1_in <= inside_box; s1_last <= last;
      s1_op <= pfb_pkg::cap16(opacity);
      s1_r <= pfb_pkg::cap16(red);
      s1_g <= pfb_pkg::cap16(green);
      s1_bl <= pfb_pkg::cap16(blue);
    end
  end

  // Stage 2: three conic products.
  logic signed [40:0] s2_pa, s2_pb, s2_pc;
  logic s2_in, s2_last;
  logic [16:0] s2_op, s2_r, s2_g, s2_bl;
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pa <= 41'(s1_a * s1_xx);
      s2_pb <= 41'(s1_b * s1_xy);
      s2_pc <= 41'(s1_c * s1_yy);
      s2_in <= s1_in; s2_last <= s1_last;
      s2_op <= s1_op; s2_r <= s1_r; s2_g <= s1_g; s2_bl <= s1_bl;
    end
  end

  // Stage 3: sum, sign test, table lookup. The index scales quad by the
  // table size, a constant.
  logic signed [42:0] quad;
  logic [54:0] hi;
  logic [16:0] weight_c;
  always_comb begin
    quad = 43'(s2_pa) + 43'(s2_pb) + 43'(s2_pb) + 43'(s2_pc);
    hi = (55'($unsigned(quad)) * 55'(EXP_TABLE_ENTRIES)) >> 22;
    weight_c = (hi < 55'(EXP_TABLE_ENTRIES)) ? exp_rom[hi[IDXW-1:0]] : 17'd0;
  end

  logic [16:0] s3_w;
  logic s3_keep, s3_last;
  logic [16:0] s3_op, s3_r, s3_g, s3_bl;
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_w <= weight_c;
      s3_keep <= s2_in && !quad[42];
      s3_last <= s2_last;
      s3_op <= s2_op; s3_r <= s2_r; s3_g <= s2_g; s3_bl <= s2_bl;
    end
  end

  // Stage 4: alpha and its threshold.
  logic [33:0] ap;
  logic [17:0] araw;
  logic [15:0] alpha_c;
  always_comb begin
    ap = s3_op * s3_w + 34'd32768;
    araw = ap[33:16];
    alpha_c = (araw > 18'(pfb_pkg::ALPHA_CAP)) ? pfb_pkg::ALPHA_CAP : araw[15:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.keep <= s3_keep && (alpha_c >= min_alpha);
      out_item.alpha <= alpha_c;
      out_item.red <= s3_r;
      out_item.green <= s3_g;
      out_item.blue <= s3_bl;
      out_item.last <= s3_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
    end
  end
  assign out_valid = v4;
endmodule

/* rtl/pfb_queue.sv */
// Small FIFO between the front and back parts.
// Depends on pfb_pkg for the item type.
module pfb_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  pfb_pkg::pfb_item_t wr_item,
  output logic               rd_valid,
  input  logic               rd_ready,
  output pfb_pkg::pfb_item_t rd_item
);
  localparam int AW = $clog2(DEPTH);
  pfb_pkg::pfb_item_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic wr, rd;
  assign wr_ready = cnt != (AW+1)'(DEPTH);
  assign rd_valid = cnt != '0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_item = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

/* rtl/pfb_back.sv */
// Back part: transmittance recurrence, accumulation and pixel output.
// Depends on pfb_pkg. Finishes one item before it takes the next.
module pfb_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pfb_pkg::pfb_item_t in_item,
  input  logic [15:0]        bg_red,
  input  logic [15:0]        bg_green,
  input  logic [15:0]        bg_blue,
  input  logic [15:0]        stop_t,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         pixel_red,
  output logic [7:0]         pixel_green,
  output logic [7:0]         pixel_blue,
  output logic [16:0]        remaining_transmittance,
  output logic [15:0]        contribution_count,
  output logic               busy
);
  pfb_pkg::pfb_state_t state, state_next;
  logic [16:0] transmittance;
  logic [17:0] acc_r, acc_g, acc_b;
  logic [15:0] contrib;
  logic sat_done;
  logic [16:0] wt;
  logic [16:0] t_mul;
  logic [16:0] bgt_r, bgt_g, bgt_b;

  // Output register with occupancy flag.
  logic obuf;
  logic do_item, do_out;
  logic use_item;
  assign use_item = in_item.keep && !sat_done;

  // Next state. ST_BGT after the last item registers the background terms.
  always_comb begin
    state_next = state;
    case (state)
      pfb_pkg::ST_WT: if (in_valid) state_next = pfb_pkg::ST_ACC;
      pfb_pkg::ST_ACC: state_next = in_item.last ? pfb_pkg::ST_BGT : pfb_pkg::ST_WT;
      pfb_pkg::ST_BGT: state_next = pfb_pkg::ST_OUT;
      pfb_pkg::ST_OUT: if (!obuf || out_ready) state_next = pfb_pkg::ST_WT;
      default: state_next = pfb_pkg::ST_WT;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready = 1'b0;
    do_item = 1'b0;
    do_out = 1'b0;
    case (state)
      pfb_pkg::ST_ACC: begin
        do_item = 1'b1;
        in_ready = !in_item.last;
      end
      pfb_pkg::ST_OUT: begin
        do_out = !obuf || out_ready;
        in_ready = do_out;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pfb_pkg::ST_WT;
    else state <= state_next;
  end

  function automatic logic [17:0] acc_add(input logic [17:0] a, input logic [16:0] c,
                                          input logic [16:0] w);
    logic [33:0] p;
    logic [18:0] s;
    p = c * w + 34'd32768;
    s = 19'(a) + 19'(p[33:16]);
    return (s > 19'(pfb_pkg::ACC_MAX)) ? pfb_pkg::ACC_MAX : s[17:0];
  endfunction

  function automatic logic [7:0] to8(input logic [17:0] a, input logic [16:0] bt);
    logic [18:0] v;
    logic [26:0] p;
    v = 19'(a) + 19'(bt);
    p = 27'(v) * 27'd255 + 27'd32768;
    return (p[26:16] > 11'd255) ? 8'd255 : p[23:16];
  endfunction

  // Products of the item step and background terms, registered.
  logic [33:0] pw, pt;
  logic [32:0] pbr, pbg, pbb;
  always_comb begin
    pw = in_item.alpha * transmittance + 34'd32768;
    pt = transmittance * (pfb_pkg::Q16_ONE - 17'(in_item.alpha)) + 34'd32768;
    pbr = bg_red * transmittance + 33'd32768;
    pbg = bg_green * transmittance + 33'd32768;
    pbb = bg_blue * transmittance + 33'd32768;
  end

  always_ff @(posedge clk) begin
    wt <= pw[32:16];
    t_mul <= pt[32:16];
    bgt_r <= pbr[32:16];
    bgt_g <= pbg[32:16];
    bgt_b <= pbb[32:16];
  end

  // Pixel state update.
  always_ff @(posedge clk) begin
    if (rst || do_out) begin
      transmittance <= pfb_pkg::Q16_ONE;
      acc_r <= '0; acc_g <= '0; acc_b <= '0;
      contrib <= '0;
      sat_done <= 1'b0;
    end else if (do_item && use_item) begin
      acc_r <= acc_add(acc_r, in_item.red, wt);
      acc_g <= acc_add(acc_g, in_item.green, wt);
      acc_b <= acc_add(acc_b, in_item.blue, wt);
      transmittance <= t_mul;
      if (contrib != pfb_pkg::COUNT_MAX) contrib <= contrib + 16'd1;
      if (t_mul < 17'(stop_t)) sat_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_out) begin
      pixel_red <= to8(acc_r, bgt_r);
      pixel_green <= to8(acc_g, bgt_g);
      pixel_blue <= to8(acc_b, bgt_b);
      remaining_transmittance <= transmittance;
      contribution_count <= contrib;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) obuf <= 1'b0;
    else if (do_out) obuf <= 1'b1;
    else if (out_ready) obuf <= 1'b0;
  end
  assign out_valid = obuf;
  assign busy = state != pfb_pkg::ST_WT;
endmodule

/* rtl/pixel_front_to_back_composite_core.sv */
// Top level of the splat compositing core: config registers and wiring.
// Depends on pfb_pkg, pfb_front, pfb_queue, pfb_back and the macros header.
// Composites a depth-ordered stream of splats into one RGB pixel per run
// ending in tlast. The front pipeline (four stages: offset products, conic
// products, table lookup, alpha) takes one beat a cycle unless stalled; the
// back part runs the transmittance recurrence, one multiply step and one
// accumulate step per splat, finishing both before it takes the next; after
// the last splat of a pixel it forms the background term and loads the
// output register. A four-entry queue parts front and back; once it fills,
// the input stalls. A stalled output holds the back part in its output state
// until the pixel is taken.
`include "pixel_front_to_back_composite_core_macros.svh"
module pixel_front_to_back_composite_core #(
  parameter int EXP_TABLE_ENTRIES = 256,
  parameter int MAX_RADIUS        = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // offset_x[7:0], offset_y[15:8], box_radius[22:16], conic_a[46:23],
  // conic_b[70:47], conic_c[94:71], opacity[111:95], red[128:112],
  // green[145:129], blue[162:146], zero fill to 168
  input  logic [167:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16],
  // remaining_transmittance[40:24], contribution_count[56:41], zero fill to 64
  output logic [63:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  logic [15:0] bg_red, bg_green, bg_blue, min_alpha, stop_t;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bg_red <= 16'd5140; bg_green <= 16'd5140; bg_blue <= 16'd5140;
      min_alpha <= 16'd257; stop_t <= 16'd7;
    end else if (cfg_we) begin
      case (cfg_index)
        pfb_pkg::REG_BG_RED:    bg_red <= cfg_data;
        pfb_pkg::REG_BG_GREEN:  bg_green <= cfg_data;
        pfb_pkg::REG_BG_BLUE:   bg_blue <= cfg_data;
        pfb_pkg::REG_MIN_ALPHA: min_alpha <= cfg_data;
        pfb_pkg::REG_STOP_T:    stop_t <= cfg_data;
        default: ;
      endcase
    end
  end

  logic f_valid, f_ready, q_valid, q_ready, b_busy;
  pfb_pkg::pfb_item_t f_item, q_item;
  logic [7:0] pr, pg, pb;
  logic [16:0] rt;
  logic [15:0] cc;

  pfb_front #(.EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES), .MAX_RADIUS(MAX_RADIUS)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .offset_x($signed(s_axis_tdata[7:0])), .offset_y($signed(s_axis_tdata[15:8])),
    .box_radius(s_axis_tdata[22:16]),
    .conic_a($signed(s_axis_tdata[46:23])), .conic_b($signed(s_axis_tdata[70:47])),
    .conic_c($signed(s_axis_tdata[94:71])),
    .opacity(s_axis_tdata[111:95]), .red(s_axis_tdata[128:112]),
    .green(s_axis_tdata[145:129]), .blue(s_axis_tdata[162:146]),
    .last(s_axis_tlast), .min_alpha,
    .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
  );

  pfb_queue #(.DEPTH(4)) u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
  );

  pfb_back u_back (
    .clk, .rst,
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .bg_red, .bg_green, .bg_blue, .stop_t,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .pixel_red(pr), .pixel_green(pg), .pixel_blue(pb),
    .remaining_transmittance(rt), .contribution_count(cc), .busy(b_busy)
  );

  assign m_axis_tdata = {7'd0, cc, rt, pb, pg, pr};

  // Checks on the queue and the back part.
  `PFB_ASSERT_IMP(a_pop_needs_data, clk, rst, q_ready, q_valid || !b_busy,
                  "back part popped an empty queue")
  `PFB_ASSERT_IMP(a_t_range, clk, rst, m_axis_tvalid, rt <= pfb_pkg::Q16_ONE,
                  "transmittance above one")
  `PFB_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")
endmodule
